// File: sv/overflow_chained_hash_table_macros.svh
// Assertion helpers for the overflow chained hash table.
// Each macro expects clk and rst to be visible where it is used.
`ifndef OVERFLOW_CHAINED_HASH_TABLE_MACROS_SVH
`define OVERFLOW_CHAINED_HASH_TABLE_MACROS_SVH

// Same-cycle implication.
`define OCHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OCHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ocht_pkg.sv
package ocht_pkg;

  // Default geometry.
  localparam int HOME_BUCKETS_DEF = 16;
  localparam int TABLE_SLOTS_DEF  = 32;
  localparam int KEY_BITS_DEF     = 32;

  // Fixed field widths on the stream ports.
  localparam int KEY_FIELD_W    = 32;
  localparam int STATUS_W       = 3;
  localparam int SLOT_FIELD_W   = 5;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

// File: sv/overflow_chained_hash_table.sv
// Hash table with home buckets and a separate overflow area, chained by links.
// Input channel s_axis: one transfer is one request. tuser[0] selects insert
// (0) or remove (1); tdata carries the 32-bit key, of which the low KEY_BITS
// bits are used. Output channel m_axis: exactly one transfer per request,
// tdata = {slot, status}: status in bits 2:0, slot in bits 7:3.
// The block works on one request at a time; s_axis_tready is high only while
// it is idle. An accepted request first finds its home bucket; when
// HOME_BUCKETS is not a power of two, the home index is computed by
// reciprocal multiplication in the steps MP_LO, MP_HI and MP_REM. The
// block then reads the home bucket and follows chain links, one key/link
// memory read per cycle; an insert that reaches the end of the chain scans
// the overflow slots, one per cycle. A remove that pulls a successor forward
// passes through S_SUCC, and an insert that links an overflow slot S_LINK.
// The result waits in an output register; while the receiver stalls, the
// block finishes its next request and then holds it until the register frees.
// Reset (rst, synchronous, active high) empties the table at once by clearing
// the per-slot used bits; key and link memories are not cleared.
`include "overflow_chained_hash_table_macros.svh"

module overflow_chained_hash_table #(
  parameter int HOME_BUCKETS = ocht_pkg::HOME_BUCKETS_DEF,
  parameter int TABLE_SLOTS  = ocht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BITS     = ocht_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key[31:0]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // status[2:0], slot[7:3]
);
  import ocht_pkg::*;

  localparam int HOME_EFF  = (HOME_BUCKETS < TABLE_SLOTS) ? HOME_BUCKETS : TABLE_SLOTS;
  localparam int KEY_W     = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int LINK_W    = SLOT_W + 1;
  localparam int STEP_W    = $clog2(TABLE_SLOTS + 1);
  localparam bit HOME_POW2 = ((HOME_EFF & (HOME_EFF - 1)) == 0);
  localparam bit NO_OVF    = (HOME_EFF >= TABLE_SLOTS);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(TABLE_SLOTS);

  // Reciprocal of the home bucket count, exact for every 32-bit key.
  localparam int HALF_W  = KEY_FIELD_W / 2;
  localparam int MOD_SH  = KEY_FIELD_W + $clog2(HOME_EFF);
  localparam int RECIP_W = KEY_FIELD_W + 1;
  localparam int MUL_W   = HALF_W + RECIP_W;
  localparam int ACC_W   = KEY_FIELD_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << MOD_SH) + 64'(HOME_EFF - 1)) / 64'(HOME_EFF);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_HOME = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_SUCC = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_LINK = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // Steps of the home index computation.
  localparam logic [1:0] MP_LO  = 2'd0;
  localparam logic [1:0] MP_HI  = 2'd1;
  localparam logic [1:0] MP_REM = 2'd2;

  // Control registers.
  logic [2:0]             state, state_next;
  logic                   op, op_next;
  logic [KEY_W-1:0]       k, k_next;
  logic [ACC_W-1:0]       acc, acc_next;
  logic [1:0]             mod_phase, mod_phase_next;
  logic [SLOT_W-1:0]      cur, cur_next;
  logic [SLOT_W-1:0]      prev, prev_next;
  logic                   have_prev, have_prev_next;
  logic [SLOT_W-1:0]      alt, alt_next;
  logic [STEP_W-1:0]      steps, steps_next;
  logic [SLOT_W-1:0]      scan_idx, scan_idx_next;
  logic [STATUS_W-1:0]    res_status, res_status_next;
  logic [SLOT_W-1:0]      res_slot, res_slot_next;
  logic [TABLE_SLOTS-1:0] used, used_next;
  logic                   out_valid, out_valid_next;
  logic [STATUS_W-1:0]    out_status, out_status_next;
  logic [SLOT_FIELD_W-1:0] out_slot, out_slot_next;

  // Key and link memories with registered reads.
  logic [KEY_W-1:0]  key_mem  [TABLE_SLOTS];
  logic [LINK_W-1:0] link_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]  key_rd;
  logic [LINK_W-1:0] link_rd;
  logic [SLOT_W-1:0] rd_addr;
  logic              kw_en, lw_en;
  logic [SLOT_W-1:0] kw_addr, lw_addr;
  logic [KEY_W-1:0]  kw_data;
  logic [LINK_W-1:0] lw_data;

  // Shared datapath helpers.
  logic [KEY_FIELD_W-1:0] k_ext, quot, quot_mul, mod_rem;
  logic [HALF_W-1:0]      mul_a;
  logic [MUL_W-1:0]       mul_prod;
  logic [ACC_W-1:0]       acc_quot;
  logic [SLOT_W-1:0]      link_idx;
  logic                   has_succ, key_match;
  logic [STEP_W-1:0]      steps_inc;

  // Shared multiplier: one key half times the reciprocal per cycle, then the
  // quotient is scaled back and taken off the key to leave the remainder.
  assign k_ext    = KEY_FIELD_W'(k);
  assign mul_a    = (mod_phase == MP_LO) ? k_ext[HALF_W-1:0] : k_ext[KEY_FIELD_W-1:HALF_W];
  assign mul_prod = MUL_W'(mul_a) * MUL_W'(RECIP);
  assign acc_quot = acc >> MOD_SH;
  assign quot     = acc_quot[KEY_FIELD_W-1:0];
  assign quot_mul = quot * KEY_FIELD_W'(HOME_EFF);
  assign mod_rem  = k_ext - quot_mul;

  // Chain inspection of the entry just read.
  assign link_idx  = link_rd[SLOT_W-1:0];
  assign has_succ  = (link_rd < LINK_W'(TABLE_SLOTS)) && used[link_idx];
  assign key_match = (key_rd == k);
  assign steps_inc = steps + STEP_W'(1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_slot, out_status};

  // Sequencer.
  always_comb begin
    state_next      = state;
    op_next         = op;
    k_next          = k;
    acc_next        = acc;
    mod_phase_next  = mod_phase;
    cur_next        = cur;
    prev_next       = prev;
    have_prev_next  = have_prev;
    alt_next        = alt;
    steps_next      = steps;
    scan_idx_next   = scan_idx;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    used_next       = used;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_slot_next   = out_slot;
    rd_addr         = cur;
    kw_en           = 1'b0;
    kw_addr         = cur;
    kw_data         = k;
    lw_en           = 1'b0;
    lw_addr         = cur;
    lw_data         = LINK_NONE;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_next        = s_axis_tuser;
          k_next         = s_axis_tdata[KEY_W-1:0];
          have_prev_next = 1'b0;
          steps_next     = '0;
          mod_phase_next = MP_LO;
          if (HOME_POW2) begin
            cur_next   = SLOT_W'(s_axis_tdata[KEY_W-1:0] & KEY_W'(HOME_EFF - 1));
            state_next = S_HOME;
          end else begin
            state_next = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (mod_phase == MP_LO) begin
          acc_next       = ACC_W'(mul_prod);
          mod_phase_next = MP_HI;
        end else if (mod_phase == MP_HI) begin
          acc_next       = acc + {mul_prod, {HALF_W{1'b0}}};
          mod_phase_next = MP_REM;
        end else begin
          cur_next   = SLOT_W'(mod_rem);
          state_next = S_HOME;
        end
      end

      S_HOME: begin
        if (used[cur]) begin
          state_next = S_LOOK;
        end else if (op == REQ_INSERT) begin
          kw_en           = 1'b1;
          lw_en           = 1'b1;
          used_next[cur]  = 1'b1;
          res_status_next = ST_INSERTED;
          res_slot_next   = cur;
          state_next      = S_DONE;
        end else begin
          res_status_next = ST_NOT_FOUND;
          res_slot_next   = '0;
          state_next      = S_DONE;
        end
      end

      S_LOOK: begin
        if (key_match) begin
          if (op == REQ_INSERT) begin
            res_status_next = ST_DUPLICATE;
            res_slot_next   = '0;
            state_next      = S_DONE;
          end else if (has_succ) begin
            // Fetch the successor so it can be pulled forward.
            alt_next   = link_idx;
            rd_addr    = link_idx;
            state_next = S_SUCC;
          end else begin
            // Tail entry: free it and cut the predecessor link.
            used_next[cur]  = 1'b0;
            lw_en           = have_prev;
            lw_addr         = prev;
            res_status_next = ST_REMOVED;
            res_slot_next   = cur;
            state_next      = S_DONE;
          end
        end else if (!has_succ || steps_inc == STEP_W'(TABLE_SLOTS)) begin
          // End of chain or walk bound reached.
          if (has_succ) begin
            cur_next = link_idx;
          end
          if (op == REQ_INSERT) begin
            if (NO_OVF) begin
              res_status_next = ST_FULL;
              res_slot_next   = '0;
              state_next      = S_DONE;
            end else begin
              scan_idx_next = SLOT_W'(HOME_EFF);
              state_next    = S_SCAN;
            end
          end else begin
            res_status_next = ST_NOT_FOUND;
            res_slot_next   = '0;
            state_next      = S_DONE;
          end
        end else begin
          // Follow the link; the read is issued now.
          prev_next      = cur;
          have_prev_next = 1'b1;
          cur_next       = link_idx;
          steps_next     = steps_inc;
          rd_addr        = link_idx;
        end
      end

      S_SUCC: begin
        kw_en           = 1'b1;
        kw_data         = key_rd;
        lw_en           = 1'b1;
        lw_data         = link_rd;
        used_next[alt]  = 1'b0;
        res_status_next = ST_REMOVED;
        res_slot_next   = alt;
        state_next      = S_DONE;
      end

      S_SCAN: begin
        if (!used[scan_idx]) begin
          kw_en               = 1'b1;
          kw_addr             = scan_idx;
          lw_en               = 1'b1;
          lw_addr             = scan_idx;
          used_next[scan_idx] = 1'b1;
          alt_next            = scan_idx;
          state_next          = S_LINK;
        end else if (scan_idx == SLOT_W'(TABLE_SLOTS - 1)) begin
          res_status_next = ST_FULL;
          res_slot_next   = '0;
          state_next      = S_DONE;
        end else begin
          scan_idx_next = scan_idx + SLOT_W'(1);
        end
      end

      S_LINK: begin
        lw_en           = 1'b1;
        lw_data         = {1'b0, alt};
        res_status_next = ST_INSERTED;
        res_slot_next   = alt;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_slot_next   = SLOT_FIELD_W'(res_slot);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      out_valid <= out_valid_next;
    end
    op         <= op_next;
    k          <= k_next;
    acc        <= acc_next;
    mod_phase  <= mod_phase_next;
    cur        <= cur_next;
    prev       <= prev_next;
    have_prev  <= have_prev_next;
    alt        <= alt_next;
    steps      <= steps_next;
    scan_idx   <= scan_idx_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    out_status <= out_status_next;
    out_slot   <= out_slot_next;
  end

  // Memory write and read ports.
  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_data;
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    key_rd  <= key_mem[rd_addr];
    link_rd <= link_mem[rd_addr];
  end

  // Checks on the sequencer and the result register.
  `OCHT_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, state != S_IDLE, "accepted request did not start")
  `OCHT_ASSERT_NEXT(a_done_loads, state == S_DONE && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid && state == S_IDLE, "finished result not loaded")
  `OCHT_ASSERT_NOW(a_quiet_slot, m_axis_tvalid && (out_status == ST_DUPLICATE || out_status == ST_FULL || out_status == ST_NOT_FOUND), out_slot == '0, "slot nonzero on unchanged table")
  `OCHT_ASSERT_NOW(a_scan_range, state == S_SCAN, scan_idx >= SLOT_W'(HOME_EFF), "overflow scan below overflow area")

endmodule
